// ----- rtl/bounded_min_heap_queue_defines.svh -----
// Assertion macros for the bounded min-heap queue.
// Depends on a clk_i and rst_ni in the scope where the macros are used.
`ifndef BOUNDED_MIN_HEAP_QUEUE_DEFINES_SVH
`define BOUNDED_MIN_HEAP_QUEUE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define BMHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition leads to another one on the next clock edge.
`define BMHQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/bmhq_pkg.sv -----
// Shared constants and codes for the bounded min-heap queue.
// No dependencies; used by the channel interfaces and the top level.
package bmhq_pkg;

  localparam int DEPTH     = 1024;
  localparam int KEY_WIDTH = 32;

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int JW    = CW + 1;
  localparam int CAP_W = 11;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_KEYS = CFG_IDX_W'(1);

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(1024);

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_PUSH   = 2'd1;
  localparam logic [1:0] ACT_POP    = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_REPLACED  = 3'd1;
  localparam logic [2:0] ST_DROPPED   = 3'd2;
  localparam logic [2:0] ST_PUSHED    = 3'd3;
  localparam logic [2:0] ST_POPPED    = 3'd4;
  localparam logic [2:0] ST_POP_EMPTY = 3'd5;
  localparam logic [2:0] ST_CLEARED   = 3'd6;
  localparam logic [2:0] ST_OVERFLOW  = 3'd7;

  typedef logic [KEY_WIDTH-1:0] key_t;

endpackage

// ----- rtl/bmhq_if.sv -----
// Valid/ready channel interfaces for the bounded min-heap queue.
// Depends on bmhq_pkg for field widths.
interface bmhq_cfg_if;
  import bmhq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface bmhq_req_if;
  import bmhq_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  key_t       key_in;
  modport source (output valid, action, key_in, input ready);
  modport sink (input valid, action, key_in, output ready);
endinterface

interface bmhq_rsp_if;
  import bmhq_pkg::*;
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  key_t          out_key;
  logic          out_valid;
  key_t          root_key;
  logic          root_valid;
  logic [CW-1:0] count;
  modport source (output valid, status, out_key, out_valid, root_key, root_valid, count,
                  input ready);
  modport sink (input valid, status, out_key, out_valid, root_key, root_valid, count,
                output ready);
endinterface

// ----- rtl/bounded_min_heap_queue.sv -----
// Top level of the bounded min-heap queue: sequencer, key store and compare unit.
// Depends on bmhq_pkg, the channel interfaces in bmhq_if.sv and the assertion
// macros in bounded_min_heap_queue_defines.svh.
//
// Usage: a request word on req_i carries an action (bounded insert, push, pop,
// clear) and a key; every request yields exactly one response word on rsp_o with
// a status, the released key if any, the root key and the key count. The cfg_i
// channel writes the capacity and the signed compare mode; it is always ready.
// Write it only while the block is idle; the block itself does not enforce this.
// The block takes one request at a time; req_i.ready is high only when idle, and
// the next word is taken no earlier than the cycle after a response is loaded.
// A clear, drop, overflow or empty pop goes straight to the finish state.
// An insert or push sifts up with a read and a compare step per level moved,
// and writes the key when it reaches the root or stops below it.
// A replace or pop sifts down through the single memory read port and the single
// key comparator, with read, child select and compare steps per level.
// Reset empties the heap without touching the store, sets the capacity to 1024
// and selects unsigned keys. A stalled response is held in the output register;
// the next request may be accepted meanwhile, and its result waits until the
// output register has been taken.
`include "bounded_min_heap_queue_defines.svh"

module bounded_min_heap_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  bmhq_cfg_if.sink         cfg_i,
  bmhq_req_if.sink         req_i,
  bmhq_rsp_if.source       rsp_o
);
  import bmhq_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_POP_LD = 4'd1;
  localparam logic [3:0] S_UP_RD  = 4'd2;
  localparam logic [3:0] S_UP_CMP = 4'd3;
  localparam logic [3:0] S_DN_RD1 = 4'd4;
  localparam logic [3:0] S_DN_RD2 = 4'd5;
  localparam logic [3:0] S_DN_SEL = 4'd6;
  localparam logic [3:0] S_DN_CMP = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  localparam int MW = (CW > CAP_W) ? CW : CAP_W;

  key_t mem [DEPTH];

  logic [3:0]      state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [CW-1:0]   i_q, i_d;
  logic [JW-1:0]   j_q, j_d;
  key_t            root_q, root_d;
  key_t            node_q, node_d;
  key_t            cval_q, cval_d;
  key_t            rdata_q;
  logic [2:0]      status_q, status_d;
  key_t            okey_q, okey_d;
  logic            okv_q, okv_d;
  logic [CAP_W-1:0] capacity_q;
  logic            signed_q;

  logic            rsp_vld_q, rsp_vld_d;
  logic [2:0]      rsp_status_q;
  key_t            rsp_okey_q, rsp_root_q;
  logic            rsp_okv_q, rsp_rootv_q;
  logic [CW-1:0]   rsp_count_q;
  logic            rsp_load;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  key_t            wdata;
  key_t            cmp_a, cmp_b, smask;
  logic            cmp_lt;
  logic [CW-1:0]   eff_cap;
  logic [JW-1:0]   j_left;

  assign smask  = signed_q ? {1'b1, {(KEY_WIDTH-1){1'b0}}} : '0;
  assign cmp_lt = (cmp_a ^ smask) < (cmp_b ^ smask);
  assign eff_cap = (MW'(capacity_q) > MW'(DEPTH)) ? CW'(DEPTH) : CW'(capacity_q);
  assign j_left = {i_q, 1'b0};

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_load    = (state_q == S_FIN) && (!rsp_vld_q || rsp_o.ready);

  always_comb begin
    cmp_a = node_q;
    cmp_b = rdata_q;
    case (state_q)
      S_IDLE: begin
        cmp_a = root_q;
        cmp_b = req_i.key_in;
      end
      S_DN_SEL: begin
        cmp_a = rdata_q;
        cmp_b = cval_q;
      end
      S_DN_CMP: begin
        cmp_a = cval_q;
        cmp_b = node_q;
      end
      default: begin
        cmp_a = node_q;
        cmp_b = rdata_q;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    i_d      = i_q;
    j_d      = j_q;
    node_d   = node_q;
    cval_d   = cval_q;
    status_d = status_q;
    okey_d   = okey_q;
    okv_d    = okv_q;
    we       = 1'b0;
    waddr    = AW'(i_q - CW'(1));
    wdata    = node_q;
    raddr    = '0;
    case (state_q)
      S_IDLE: begin
        raddr = AW'(count_q - CW'(1));
        if (req_i.valid) begin
          okey_d = '0;
          okv_d  = 1'b0;
          case (req_i.action)
            ACT_INSERT, ACT_PUSH: begin
              if ((req_i.action == ACT_INSERT && count_q < eff_cap) ||
                  (req_i.action == ACT_PUSH && count_q < CW'(DEPTH))) begin
                count_d  = count_q + CW'(1);
                i_d      = count_q + CW'(1);
                node_d   = req_i.key_in;
                status_d = (req_i.action == ACT_INSERT) ? ST_ADDED : ST_PUSHED;
                state_d  = S_UP_RD;
              end else if (req_i.action == ACT_INSERT && count_q != '0 && cmp_lt) begin
                status_d = ST_REPLACED;
                okey_d   = root_q;
                okv_d    = 1'b1;
                node_d   = req_i.key_in;
                i_d      = CW'(1);
                state_d  = S_DN_RD1;
              end else begin
                status_d = (req_i.action == ACT_INSERT) ? ST_DROPPED : ST_OVERFLOW;
                okey_d   = req_i.key_in;
                okv_d    = 1'b1;
                state_d  = S_FIN;
              end
            end
            ACT_POP: begin
              if (count_q != '0) begin
                status_d = ST_POPPED;
                okey_d   = root_q;
                okv_d    = 1'b1;
                count_d  = count_q - CW'(1);
                i_d      = CW'(1);
                state_d  = S_POP_LD;
              end else begin
                status_d = ST_POP_EMPTY;
                state_d  = S_FIN;
              end
            end
            default: begin
              count_d  = '0;
              status_d = ST_CLEARED;
              state_d  = S_FIN;
            end
          endcase
        end
      end
      S_POP_LD: begin
        node_d  = rdata_q;
        state_d = S_DN_RD1;
      end
      S_UP_RD: begin
        if (i_q == CW'(1)) begin
          we      = 1'b1;
          state_d = S_FIN;
        end else begin
          raddr   = AW'((i_q >> 1) - CW'(1));
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (cmp_lt) begin
          wdata   = rdata_q;
          i_d     = i_q >> 1;
          state_d = S_UP_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DN_RD1: begin
        if (j_left > JW'(count_q)) begin
          we      = 1'b1;
          state_d = S_FIN;
        end else begin
          raddr   = AW'(j_left - JW'(1));
          j_d     = j_left;
          state_d = S_DN_RD2;
        end
      end
      S_DN_RD2: begin
        cval_d = rdata_q;
        raddr  = AW'(j_q);
        if (j_q < JW'(count_q)) begin
          state_d = S_DN_SEL;
        end else begin
          state_d = S_DN_CMP;
        end
      end
      S_DN_SEL: begin
        if (cmp_lt) begin
          cval_d = rdata_q;
          j_d    = j_q + JW'(1);
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP: begin
        we    = 1'b1;
        if (cmp_lt) begin
          wdata   = cval_q;
          i_d     = CW'(j_q);
          state_d = S_DN_RD1;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (rsp_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    root_d = root_q;
    if (we && waddr == '0) begin
      root_d = wdata;
    end
  end

  always_comb begin
    rsp_vld_d = rsp_vld_q && !rsp_o.ready;
    if (rsp_load) begin
      rsp_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      rsp_vld_q  <= 1'b0;
      capacity_q <= CAPACITY_RESET;
      signed_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rsp_vld_q <= rsp_vld_d;
      if (cfg_i.valid && cfg_i.index == CFG_CAPACITY) begin
        capacity_q <= CAP_W'(cfg_i.data);
      end
      if (cfg_i.valid && cfg_i.index == CFG_SIGNED_KEYS) begin
        signed_q <= cfg_i.data[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    j_q      <= j_d;
    root_q   <= root_d;
    node_q   <= node_d;
    cval_q   <= cval_d;
    status_q <= status_d;
    okey_q   <= okey_d;
    okv_q    <= okv_d;
    if (rsp_load) begin
      rsp_status_q <= status_q;
      rsp_okey_q   <= okey_q;
      rsp_okv_q    <= okv_q;
      rsp_root_q   <= (count_q != '0) ? root_q : '0;
      rsp_rootv_q  <= (count_q != '0);
      rsp_count_q  <= count_q;
    end
  end

  assign rsp_o.valid      = rsp_vld_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.out_key    = rsp_okey_q;
  assign rsp_o.out_valid  = rsp_okv_q;
  assign rsp_o.root_key   = rsp_root_q;
  assign rsp_o.root_valid = rsp_rootv_q;
  assign rsp_o.count      = rsp_count_q;

  `BMHQ_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "Key count exceeds the store depth.")
  `BMHQ_ASSERT_NEXT(a_busy_after_accept, req_i.valid && req_i.ready, state_q != S_IDLE,
                    "Sequencer did not leave idle after accepting a word.")
  `BMHQ_ASSERT(a_up_index, state_q == S_UP_RD |-> i_q != '0 && i_q <= count_q,
               "Sift-up position lies outside the heap.")
  `BMHQ_ASSERT_NEXT(a_rsp_loaded, rsp_load, rsp_vld_q && state_q == S_IDLE,
                    "Finished result was not presented.")

endmodule

// ----- verif/tb_bounded_min_heap_queue.sv -----
// Testbench for bounded_min_heap_queue: drives request and config words, predicts each
// response with a shadow heap and compares every field. Depends on bmhq_pkg and the
// channel interfaces in bmhq_if.sv.
module tb_bounded_min_heap_queue;
  import bmhq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT    = 16;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    bit                    is_cfg;
    logic [1:0]            action;
    key_t                  key;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } heap_word_t;

  typedef struct {
    logic [2:0]    status;
    key_t          out_key;
    logic          out_valid;
    key_t          root_key;
    logic          root_valid;
    logic [CW-1:0] count;
  } heap_rsp_t;

  logic clk;
  logic rst_n;

  bmhq_cfg_if cfg_if ();
  bmhq_req_if req_if ();
  bmhq_rsp_if rsp_if ();

  bounded_min_heap_queue u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  heap_word_t pending_words[$];
  heap_rsp_t  due_results[$];

  key_t shadow_heap [1:DEPTH];
  int   shadow_count;
  int   shadow_cap;
  bit   shadow_signed;

  int req_taken;
  int rsp_taken;
  int errors;
  int cycle_cnt;
  bit quiet;

  assign quiet = (cycle_cnt % 8000) >= 5500;

  always #5 clk = ~clk;

  function automatic bit key_lt(key_t a, key_t b);
    if (shadow_signed) begin
      return $signed(a) < $signed(b);
    end
    return a < b;
  endfunction

  function automatic void heap_sift_up();
    int   i;
    int   j;
    key_t node;
    i = shadow_count;
    j = i >> 1;
    node = shadow_heap[i];
    while (j > 0 && key_lt(node, shadow_heap[j])) begin
      shadow_heap[i] = shadow_heap[j];
      i = j;
      j = j >> 1;
    end
    shadow_heap[i] = node;
  endfunction

  function automatic void heap_sift_down();
    int   i;
    int   j;
    int   k;
    key_t node;
    i = 1;
    j = 2;
    k = 3;
    node = shadow_heap[1];
    if (k <= shadow_count && key_lt(shadow_heap[k], shadow_heap[j])) j = k;
    while (j <= shadow_count && key_lt(shadow_heap[j], node)) begin
      shadow_heap[i] = shadow_heap[j];
      i = j;
      j = i << 1;
      k = j + 1;
      if (k <= shadow_count && key_lt(shadow_heap[k], shadow_heap[j])) j = k;
    end
    shadow_heap[i] = node;
  endfunction

  function automatic logic [2:0] heap_push(key_t key);
    if (shadow_count >= DEPTH) return ST_OVERFLOW;
    shadow_count++;
    shadow_heap[shadow_count] = key;
    heap_sift_up();
    return ST_PUSHED;
  endfunction

  function automatic heap_rsp_t heap_step(logic [1:0] action, key_t key);
    heap_rsp_t r;
    int        cap;
    r = '{default: '0};
    cap = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    case (action)
      ACT_INSERT: begin
        if (shadow_count < cap) begin
          void'(heap_push(key));
          r.status = ST_ADDED;
        end else if (shadow_count > 0 && key_lt(shadow_heap[1], key)) begin
          r.out_key = shadow_heap[1];
          r.out_valid = 1'b1;
          shadow_heap[1] = key;
          heap_sift_down();
          r.status = ST_REPLACED;
        end else begin
          r.out_key = key;
          r.out_valid = 1'b1;
          r.status = ST_DROPPED;
        end
      end
      ACT_PUSH: begin
        r.status = heap_push(key);
        if (r.status == ST_OVERFLOW) begin
          r.out_key = key;
          r.out_valid = 1'b1;
        end
      end
      ACT_POP: begin
        if (shadow_count > 0) begin
          r.out_key = shadow_heap[1];
          r.out_valid = 1'b1;
          shadow_heap[1] = shadow_heap[shadow_count];
          shadow_count--;
          heap_sift_down();
          r.status = ST_POPPED;
        end else begin
          r.status = ST_POP_EMPTY;
        end
      end
      default: begin
        shadow_count = 0;
        r.status = ST_CLEARED;
      end
    endcase
    r.root_valid = (shadow_count > 0);
    r.root_key = (shadow_count > 0) ? shadow_heap[1] : '0;
    r.count = CW'(shadow_count);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Prediction happens when a request word is accepted; responses are checked in order.
  always @(posedge clk) begin : heap_monitor
    heap_rsp_t want;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_CAPACITY) shadow_cap = int'(cfg_if.data);
        else if (cfg_if.index == CFG_SIGNED_KEYS) shadow_signed = cfg_if.data[0];
      end
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_taken <= rsp_taken + 1;
        if (due_results.size() == 0) begin
          $display("%0t ns: response word with nothing expected, actual status %h key %h",
                   $time, rsp_if.status, rsp_if.out_key);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_if.status));
          check_field("out_key", want.out_key, rsp_if.out_key);
          check_field("out_valid", 32'(want.out_valid), 32'(rsp_if.out_valid));
          check_field("root_key", want.root_key, rsp_if.root_key);
          check_field("root_valid", 32'(want.root_valid), 32'(rsp_if.root_valid));
          check_field("count", 32'(want.count), 32'(rsp_if.count));
        end
      end
      if (req_if.valid && req_if.ready) begin
        req_taken <= req_taken + 1;
        due_results.push_back(heap_step(req_if.action, req_if.key_in));
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin : word_driver
    heap_word_t head;
    bit         req_free;
    bit         cfg_free;
    bit         idle_now;
    bit         go;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      req_if.action <= ACT_INSERT;
      req_if.key_in <= '0;
      cfg_if.valid <= 1'b0;
      cfg_if.index <= CFG_CAPACITY;
      cfg_if.data <= '0;
    end else begin
      req_free = !req_if.valid || req_if.ready;
      cfg_free = !cfg_if.valid || cfg_if.ready;
      idle_now = (req_taken + int'(req_if.valid && req_if.ready)) ==
                 (rsp_taken + int'(rsp_if.valid && rsp_if.ready));
      go = req_free && cfg_free && pending_words.size() != 0 &&
           (quiet || $urandom_range(99) >= IDLE_PCT);
      if (go && pending_words[0].is_cfg && !idle_now) go = 1'b0;
      if (go) begin
        head = pending_words.pop_front();
        if (head.is_cfg) begin
          cfg_if.valid <= 1'b1;
          cfg_if.index <= head.idx;
          cfg_if.data <= head.data;
          req_if.valid <= 1'b0;
        end else begin
          req_if.valid <= 1'b1;
          req_if.action <= head.action;
          req_if.key_in <= head.key;
          cfg_if.valid <= 1'b0;
        end
      end else begin
        if (req_free) req_if.valid <= 1'b0;
        if (cfg_free) cfg_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_req(logic [1:0] action, key_t key);
    heap_word_t w;
    w = '{default: '0};
    w.action = action;
    w.key = key;
    pending_words.push_back(w);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    heap_word_t w;
    w = '{default: '0};
    w.is_cfg = 1'b1;
    w.idx = idx;
    w.data = data;
    pending_words.push_back(w);
  endtask

  task automatic add_setting(int cap, bit sgn);
    add_cfg(CFG_CAPACITY, CFG_DATA_W'(cap));
    add_cfg(CFG_SIGNED_KEYS, CFG_DATA_W'(sgn));
  endtask

  function automatic key_t rand_key();
    int mode;
    mode = $urandom_range(9);
    if (mode < 4) return $urandom;
    if (mode < 7) return key_t'($urandom_range(15));
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [1:0] rand_action();
    int r;
    r = $urandom_range(99);
    if (r < 45) return ACT_INSERT;
    if (r < 65) return ACT_PUSH;
    if (r < 96) return ACT_POP;
    return ACT_CLEAR;
  endfunction

  task automatic add_random_phase(int n);
    repeat (n) add_req(rand_action(), rand_key());
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.action = ACT_INSERT;
    req_if.key_in = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_CAPACITY;
    cfg_if.data = '0;
    rsp_if.ready = 1'b0;
    errors = 0;
    cycle_cnt = 0;
    req_taken = 0;
    rsp_taken = 0;
    shadow_count = 0;
    shadow_cap = int'(CAPACITY_RESET);
    shadow_signed = 1'b0;
    foreach (shadow_heap[i]) shadow_heap[i] = '0;

    add_req(ACT_POP, '0);
    add_req(ACT_CLEAR, '1);
    add_req(ACT_PUSH, '0);
    add_req(ACT_PUSH, '1);
    add_req(ACT_PUSH, 32'h8000_0000);
    add_req(ACT_PUSH, 32'h7FFF_FFFF);
    add_req(ACT_INSERT, 32'd1);
    add_req(ACT_INSERT, 32'd1);
    add_req(ACT_POP, '0);
    add_req(ACT_POP, '0);
    add_req(ACT_CLEAR, '0);
    add_setting(1, 1'b1);
    add_req(ACT_INSERT, 32'd5);
    add_req(ACT_INSERT, 32'd5);
    add_req(ACT_INSERT, 32'd6);
    add_req(ACT_INSERT, '1);
    add_req(ACT_INSERT, 32'h8000_0000);
    add_req(ACT_PUSH, 32'd3);
    add_req(ACT_POP, '0);
    add_req(ACT_POP, '0);
    add_req(ACT_POP, '0);
    add_setting(0, 1'b0);
    add_req(ACT_INSERT, 32'd9);
    add_req(ACT_PUSH, 32'd1);
    add_req(ACT_INSERT, 32'd2);
    add_req(ACT_CLEAR, '0);

    add_setting($urandom_range(2, 8), 1'b0);
    add_random_phase(10);
    add_setting(1, 1'b1);
    add_random_phase(5);
    add_setting(0, 1'b0);
    add_random_phase(3);

    // Fill the whole store, then run into overflow and replace at full depth.
    add_setting(2047, 1'b0);
    add_req(ACT_CLEAR, '0);
    repeat (DEPTH) add_req(ACT_PUSH, rand_key());
    repeat (2) add_req(ACT_PUSH, rand_key());
    repeat (4) add_req(ACT_INSERT, rand_key());
    repeat (8) add_req(ACT_POP, '0);

    add_setting(1024, 1'b1);
    add_random_phase(6);
    add_setting($urandom_range(1, 1024), 1'($urandom_range(1)));
    add_random_phase(5);
    add_setting(16, 1'b1);
    add_random_phase(5);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_words.size() != 0 || req_if.valid || due_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
